@@ rtl/core/range_to_cidr_prefixes_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Range to CIDR prefixes unit: assertion macros
// Shared property macros for the checker of the prefix splitter.
// ----------------------------------------------------------------------------
`ifndef RANGE_TO_CIDR_PREFIXES_UNIT_MACROS_SVH
`define RANGE_TO_CIDR_PREFIXES_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RTCP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("range_to_cidr_prefixes_unit: same-cycle property failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RTCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("range_to_cidr_prefixes_unit: next-cycle property failed");

`endif

@@ rtl/core/rtcp_pkg.sv @@
// ----------------------------------------------------------------------------
// Range to CIDR prefixes package
// Shared constants and types of the range to CIDR prefixes unit.
// ----------------------------------------------------------------------------
package rtcp_pkg;

  localparam int ADDR_W        = 32;
  localparam int LEN_W         = 6;
  localparam int ADDR_BITS_DEF = 32;
  localparam int QUEUE_DEPTH   = 2;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } back_state_e;

endpackage

@@ rtl/core/rtcp_front.sv @@
// ----------------------------------------------------------------------------
// Range to CIDR prefixes front end
// Accepts ranges, masks them to the address width and classifies them.
// ----------------------------------------------------------------------------
module rtcp_front #(
  parameter int ADDR_BITS = rtcp_pkg::ADDR_BITS_DEF
) (
  input  logic                         start,
  output logic                         busy,
  input  logic [rtcp_pkg::ADDR_W-1:0]  range_start_i,
  input  logic [rtcp_pkg::ADDR_W-1:0]  range_end_i,
  input  rtcp_pkg::q_stat_t            q_stat_i,
  output logic                         push_o,
  output logic [2*ADDR_BITS:0]         push_data_o
);

  logic [ADDR_BITS-1:0] start_addr;
  logic [ADDR_BITS-1:0] end_addr;
  logic                 is_empty;

  assign start_addr  = range_start_i[ADDR_BITS-1:0];
  assign end_addr    = range_end_i[ADDR_BITS-1:0];
  assign is_empty    = end_addr < start_addr;
  assign busy        = q_stat_i.full;
  assign push_o      = start && !q_stat_i.full;
  assign push_data_o = {is_empty, end_addr, start_addr};

endmodule

@@ rtl/core/rtcp_queue.sv @@
// ----------------------------------------------------------------------------
// Range to CIDR prefixes queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module rtcp_queue #(
  parameter int WIDTH = 65,
  parameter int DEPTH = rtcp_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [WIDTH-1:0]   push_data_i,
  input  logic               pop_i,
  output logic [WIDTH-1:0]   pop_data_o,
  output rtcp_pkg::q_stat_t  q_stat_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign do_push = push_i && (count_q != CNT_W'(DEPTH));
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o         = entry_q[rd_ptr_q];
  assign q_stat_o.full      = (count_q == CNT_W'(DEPTH));
  assign q_stat_o.not_empty = (count_q != '0);

endmodule

@@ rtl/core/rtcp_back.sv @@
// ----------------------------------------------------------------------------
// Range to CIDR prefixes back end
// Walks a cursor through a range and emits one prefix per cycle.
// ----------------------------------------------------------------------------
module rtcp_back #(
  parameter int ADDR_BITS = rtcp_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rtcp_pkg::q_stat_t           q_stat_i,
  input  logic [2*ADDR_BITS:0]        pop_data_i,
  output logic                        pop_o,
  output logic                        valid_o,
  output logic [ADDR_BITS-1:0]        addr_o,
  output logic [rtcp_pkg::LEN_W-1:0]  len_o,
  output logic                        is_empty_o,
  output logic                        last_o
);

  localparam int KW = $clog2(ADDR_BITS + 1);

  rtcp_pkg::back_state_e state_q, state_d;

  logic [ADDR_BITS-1:0]       cur_q, cur_d;
  logic [ADDR_BITS-1:0]       end_q, end_d;
  logic                       valid_q, valid_d;
  logic [ADDR_BITS-1:0]       addr_q, addr_d;
  logic [rtcp_pkg::LEN_W-1:0] len_q, len_d;
  logic                       empty_q, empty_d;
  logic                       last_q, last_d;

  logic [ADDR_BITS:0]   rem;
  logic [ADDR_BITS:0]   size;
  logic [KW-1:0]        ks;
  logic [KW-1:0]        ka;
  logic [KW-1:0]        k;
  logic                 pair;
  logic                 fin;
  logic                 in_empty;
  logic [ADDR_BITS-1:0] in_start;
  logic [ADDR_BITS-1:0] in_end;

  assign in_empty = pop_data_i[2*ADDR_BITS];
  assign in_end   = pop_data_i[2*ADDR_BITS-1:ADDR_BITS];
  assign in_start = pop_data_i[ADDR_BITS-1:0];

  assign rem  = {1'b0, end_q} - {1'b0, cur_q} + (ADDR_BITS+1)'(1);
  assign pair = (rem == (ADDR_BITS+1)'(2));

  always_comb begin
    ks = '0;
    for (int i = 0; i <= ADDR_BITS; i++) begin
      if (rem[i]) begin
        ks = KW'(i);
      end
    end
  end

  always_comb begin
    ka = KW'(ADDR_BITS);
    for (int i = ADDR_BITS - 1; i >= 0; i--) begin
      if (cur_q[i]) begin
        ka = KW'(i);
      end
    end
  end

  assign k    = pair ? '0 : ((ks < ka) ? ks : ka);
  assign size = (ADDR_BITS+1)'(1) << k;
  assign fin  = (size == rem);

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    end_d   = end_q;
    valid_d = 1'b0;
    addr_d  = addr_q;
    len_d   = len_q;
    empty_d = empty_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    unique case (state_q)
      rtcp_pkg::ST_IDLE: begin
        if (q_stat_i.not_empty) begin
          pop_o = 1'b1;
          if (in_empty) begin
            valid_d = 1'b1;
            addr_d  = '0;
            len_d   = '0;
            empty_d = 1'b1;
            last_d  = 1'b1;
          end else begin
            cur_d   = in_start;
            end_d   = in_end;
            state_d = rtcp_pkg::ST_RUN;
          end
        end
      end
      rtcp_pkg::ST_RUN: begin
        valid_d = 1'b1;
        addr_d  = cur_q;
        len_d   = rtcp_pkg::LEN_W'(ADDR_BITS) - rtcp_pkg::LEN_W'(k);
        empty_d = 1'b0;
        last_d  = fin;
        cur_d   = cur_q + size[ADDR_BITS-1:0];
        if (fin) begin
          state_d = rtcp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rtcp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtcp_pkg::ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    end_q   <= end_d;
    addr_q  <= addr_d;
    len_q   <= len_d;
    empty_q <= empty_d;
    last_q  <= last_d;
  end

  assign valid_o    = valid_q;
  assign addr_o     = addr_q;
  assign len_o      = len_q;
  assign is_empty_o = empty_q;
  assign last_o     = last_q;

endmodule

@@ rtl/core/range_to_cidr_prefixes_unit.sv @@
// ----------------------------------------------------------------------------
// Range to CIDR prefixes unit
// Splits an inclusive IPv4 address range into its covering CIDR prefixes.
// ----------------------------------------------------------------------------
// A range is taken on the rising edge where start is high and busy is low.
// The front end classifies it and places it in a two-entry queue, so busy
// rises only when that queue is full; the back end works on one range at a
// time while up to two more wait.
// The back end loads a range into its cursor registers, then emits one prefix
// beat per cycle, in ascending order, with no gaps, the final beat marked by
// last_o. An empty range (end below start) gives a single beat with is_empty_o
// and last_o set, in the cycle after it is popped. When the back end idles, an
// accepted range passes through the queue entry, the cursor registers and the
// output registers before its first beat. Each beat comes from a combinational
// step: remaining count, alignment and size search.
// Each beat is shown for exactly one cycle, marked by valid_o; the receiver
// cannot stall. Reset empties the queue and returns the back end to idle.
// ----------------------------------------------------------------------------
module range_to_cidr_prefixes_unit #(
  parameter int ADDR_BITS = rtcp_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [rtcp_pkg::ADDR_W-1:0] range_start_i,
  input  logic [rtcp_pkg::ADDR_W-1:0] range_end_i,
  output logic                        valid_o,
  output logic [rtcp_pkg::ADDR_W-1:0] prefix_address_o,
  output logic [rtcp_pkg::LEN_W-1:0]  prefix_length_o,
  output logic                        is_empty_o,
  output logic                        last_o
);

  localparam int QW = 2 * ADDR_BITS + 1;

  rtcp_pkg::q_stat_t    q_stat;
  logic                 push;
  logic [QW-1:0]        push_data;
  logic                 pop;
  logic [QW-1:0]        pop_data;
  logic [ADDR_BITS-1:0] addr;

  rtcp_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_rtcp_front (
    .start         (start),
    .busy          (busy),
    .range_start_i (range_start_i),
    .range_end_i   (range_end_i),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  rtcp_queue #(
    .WIDTH (QW),
    .DEPTH (rtcp_pkg::QUEUE_DEPTH)
  ) u_rtcp_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .q_stat_o    (q_stat)
  );

  rtcp_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_rtcp_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .valid_o    (valid_o),
    .addr_o     (addr),
    .len_o      (prefix_length_o),
    .is_empty_o (is_empty_o),
    .last_o     (last_o)
  );

  assign prefix_address_o = rtcp_pkg::ADDR_W'(addr);

endmodule

@@ rtl/core/rtcp_checker.sv @@
// ----------------------------------------------------------------------------
// Range to CIDR prefixes checker
// Port-level properties of the range to CIDR prefixes unit.
// ----------------------------------------------------------------------------
`include "range_to_cidr_prefixes_unit_macros.svh"

module rtcp_checker #(
  parameter int ADDR_BITS = rtcp_pkg::ADDR_BITS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        valid_o,
  input logic [rtcp_pkg::ADDR_W-1:0] prefix_address_o,
  input logic [rtcp_pkg::LEN_W-1:0]  prefix_length_o,
  input logic                        is_empty_o,
  input logic                        last_o
);

  logic empty_beat;
  logic empty_fields_zero;
  logic len_in_range;
  logic more_beats;
  logic next_is_beat;

  assign empty_beat        = valid_o && is_empty_o;
  assign empty_fields_zero = (prefix_address_o == '0) && (prefix_length_o == '0);
  assign len_in_range      = prefix_length_o <= rtcp_pkg::LEN_W'(ADDR_BITS);
  assign more_beats        = valid_o && !last_o;
  assign next_is_beat      = valid_o && !is_empty_o;

  `RTCP_ASSERT_IMPLY(a_empty_is_last, clk_i, rst_ni, empty_beat, last_o)
  `RTCP_ASSERT_IMPLY(a_empty_zero, clk_i, rst_ni, empty_beat, empty_fields_zero)
  `RTCP_ASSERT_IMPLY(a_len_range, clk_i, rst_ni, valid_o, len_in_range)
  `RTCP_ASSERT_NEXT(a_beats_contiguous, clk_i, rst_ni, more_beats, next_is_beat)

endmodule

bind range_to_cidr_prefixes_unit rtcp_checker #(
  .ADDR_BITS (ADDR_BITS)
) u_rtcp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .valid_o          (valid_o),
  .prefix_address_o (prefix_address_o),
  .prefix_length_o  (prefix_length_o),
  .is_empty_o       (is_empty_o),
  .last_o           (last_o)
);

@@ dv/range_to_cidr_prefixes_unit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range to CIDR prefixes unit: checker
// Watches the range and prefix channels of the unit. Each accepted range is
// split into its expected prefix beats, and every beat the unit shows is
// compared with the oldest expected one. Failures are counted for the top.
// ----------------------------------------------------------------------------
module range_to_cidr_prefixes_unit_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic [rtcp_pkg::ADDR_W-1:0] range_start_i,
  input  logic [rtcp_pkg::ADDR_W-1:0] range_end_i,
  input  logic                        valid_i,
  input  logic [rtcp_pkg::ADDR_W-1:0] prefix_address_i,
  input  logic [rtcp_pkg::LEN_W-1:0]  prefix_length_i,
  input  logic                        is_empty_i,
  input  logic                        last_i,
  output int                          errors_o,
  output int                          pending_o,
  output int                          beats_o,
  output int                          empties_o
);

  localparam int AW = rtcp_pkg::ADDR_W;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [AW-1:0]              addr;
    logic [rtcp_pkg::LEN_W-1:0] len;
    logic                       empty;
    logic                       fin;
  } prefix_beat_t;

  prefix_beat_t expected_prefixes[$];
  prefix_beat_t want;

  initial begin
    errors_o  = 0;
    pending_o = 0;
    beats_o   = 0;
    empties_o = 0;
  end

  function automatic int unsigned top_bit(input logic [AW:0] v);
    int unsigned k;
    k = 0;
    for (int i = 0; i <= AW; i++) begin
      if (v[i]) begin
        k = i;
      end
    end
    return k;
  endfunction

  function automatic int unsigned low_zero_bits(input logic [AW-1:0] a);
    int unsigned k;
    k = 0;
    if (a == '0) begin
      return AW;
    end
    while (!a[k]) begin
      k++;
    end
    return k;
  endfunction

  function automatic void add_prefix(input logic [AW:0] addr, input int unsigned len,
                                     input logic empty, input logic fin);
    prefix_beat_t b;
    b.addr  = addr[AW-1:0];
    b.len   = len[rtcp_pkg::LEN_W-1:0];
    b.empty = empty;
    b.fin   = fin;
    expected_prefixes = {expected_prefixes, b};
  endfunction

  function automatic void split_range(input logic [AW-1:0] first,
                                      input logic [AW-1:0] final_addr);
    logic [AW:0] cur;
    logic [AW:0] lim;
    logic [AW:0] rem;
    logic [AW:0] size;
    int unsigned ks;
    int unsigned ka;
    int unsigned k;
    int          n;
    if (final_addr < first) begin
      add_prefix('0, 0, 1'b1, 1'b1);
      return;
    end
    cur = {1'b0, first};
    lim = {1'b0, final_addr};
    n   = 0;
    while (n < 2 * AW) begin
      rem = lim - cur + 1;
      if (rem == 2) begin
        add_prefix(cur, AW, 1'b0, 1'b0);
        add_prefix(cur + 1, AW, 1'b0, 1'b1);
        break;
      end
      ks   = top_bit(rem);
      ka   = low_zero_bits(cur[AW-1:0]);
      k    = (ks < ka) ? ks : ka;
      size = {{AW{1'b0}}, 1'b1} << k;
      add_prefix(cur, AW - k, 1'b0, (cur + size - 1) >= lim);
      n++;
      cur = cur + size;
      if (cur > lim) begin
        break;
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i) begin
        beats_o++;
        if (is_empty_i) begin
          empties_o++;
        end
        if (expected_prefixes.size() == 0) begin
          if (errors_o < MAX_REPORTS) begin
            $display("%0t: unexpected beat addr %h len %0d empty %b last %b", $realtime,
                     prefix_address_i, prefix_length_i, is_empty_i, last_i);
          end
          errors_o++;
        end else begin
          want = expected_prefixes.pop_front();
          if (prefix_address_i !== want.addr || prefix_length_i !== want.len ||
              is_empty_i !== want.empty || last_i !== want.fin) begin
            if (errors_o < MAX_REPORTS) begin
              $display("%0t: beat mismatch, expected addr %h len %0d empty %b last %b",
                       $realtime, want.addr, want.len, want.empty, want.fin);
              $display("%0t:                  actual addr %h len %0d empty %b last %b",
                       $realtime, prefix_address_i, prefix_length_i, is_empty_i, last_i);
            end
            errors_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        split_range(range_start_i, range_end_i);
      end
      pending_o = expected_prefixes.size();
    end
  end

endmodule

@@ dv/range_to_cidr_prefixes_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range to CIDR prefixes unit: testbench top
// Drives address ranges into the unit: a directed set of corner ranges, then
// random ranges of many shapes with and without gaps between them. The
// checker beside the unit predicts and compares every prefix beat.
// ----------------------------------------------------------------------------
module range_to_cidr_prefixes_unit_test;

  localparam int AW = rtcp_pkg::ADDR_W;
  localparam int RANDOM_RANGES = 160;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 200;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [AW-1:0]               range_start_i = '0;
  logic [AW-1:0]               range_end_i = '0;
  logic                        valid_o;
  logic [AW-1:0]               prefix_address_o;
  logic [rtcp_pkg::LEN_W-1:0]  prefix_length_o;
  logic                        is_empty_o;
  logic                        last_o;

  int errors;
  int pending;
  int beats;
  int empties;
  int cycle_count = 0;
  int ranges_sent = 0;
  bit gaps_on = 1'b1;

  always #2 clk_i = ~clk_i;

  range_to_cidr_prefixes_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .range_start_i    (range_start_i),
    .range_end_i      (range_end_i),
    .valid_o          (valid_o),
    .prefix_address_o (prefix_address_o),
    .prefix_length_o  (prefix_length_o),
    .is_empty_o       (is_empty_o),
    .last_o           (last_o)
  );

  range_to_cidr_prefixes_unit_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .range_start_i    (range_start_i),
    .range_end_i      (range_end_i),
    .valid_i          (valid_o),
    .prefix_address_i (prefix_address_o),
    .prefix_length_i  (prefix_length_o),
    .is_empty_i       (is_empty_o),
    .last_i           (last_o),
    .errors_o         (errors),
    .pending_o        (pending),
    .beats_o          (beats),
    .empties_o        (empties)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d beats outstanding.", cycle_count, pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_range(input logic [AW-1:0] first, input logic [AW-1:0] final_addr);
    int gap;
    gap = gaps_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    range_start_i <= first;
    range_end_i   <= final_addr;
    do begin
      @(posedge clk_i);
    end while (busy);
    ranges_sent++;
  endtask

  task automatic send_random_range();
    logic [AW:0]   wide_end;
    logic [AW-1:0] first;
    logic [AW-1:0] final_addr;
    logic [AW-1:0] mask;
    int unsigned   k;
    first = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        wide_end   = {1'b0, first} + $urandom_range(0, 300);
        final_addr = wide_end[AW] ? '1 : wide_end[AW-1:0];
      end
      3: begin
        wide_end   = {1'b0, first} + $urandom_range(0, 2);
        final_addr = wide_end[AW] ? '1 : wide_end[AW-1:0];
      end
      4, 5: begin
        final_addr = $urandom;
      end
      6: begin
        final_addr = first - $urandom_range(1, 1000);
        if (first == '0) begin
          first = 32'h0000_0001;
        end
      end
      7: begin
        k          = $urandom_range(0, AW);
        mask       = (k == AW) ? '1 : ((32'd1 << k) - 1);
        first      = first & ~mask;
        final_addr = first | mask;
      end
      default: begin
        k          = $urandom_range(0, AW);
        mask       = (k == AW) ? '1 : ((32'd1 << k) - 1);
        first      = (first & ~mask) + $urandom_range(0, 3);
        final_addr = ($urandom | mask) - $urandom_range(0, 3);
        if (final_addr < first) begin
          final_addr = '1;
        end
      end
    endcase
    send_range(first, final_addr);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_range(32'h0000_0000, 32'hFFFF_FFFF);
    send_range(32'h0000_0005, 32'h0000_0005);
    send_range(32'h0000_0000, 32'h0000_0000);
    send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_range(32'h0000_000A, 32'h0000_0003);
    send_range(32'hFFFF_FFFF, 32'h0000_0000);
    send_range(32'h0000_0001, 32'h0000_0000);
    send_range(32'h0000_0004, 32'h0000_0005);
    send_range(32'h0000_0005, 32'h0000_0006);
    send_range(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_range(32'h0000_0000, 32'h0000_0002);
    send_range(32'h0000_0001, 32'hFFFF_FFFE);
    send_range(32'h0000_0000, 32'hFFFF_FFFE);
    send_range(32'h0000_0001, 32'hFFFF_FFFF);
    send_range(32'h8000_0000, 32'hFFFF_FFFF);
    send_range(32'h0000_0000, 32'h7FFF_FFFF);
    send_range(32'h0A00_0000, 32'h0AFF_FFFF);
    send_range(32'hC0A8_0001, 32'hC0A8_00FE);
    send_range(32'h5555_5555, 32'hAAAA_AAAA);
    send_range(32'hAAAA_AAAA, 32'h5555_5555);

    for (int i = 0; i < RANDOM_RANGES; i++) begin
      if (i % 30 == 0) begin
        gaps_on = ((i / 30) % 2) == 0;
      end
      send_random_range();
    end
    start <= 1'b0;

    while (pending != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d ranges; checked %0d prefix beats, %0d of them for empty ranges.",
             ranges_sent, beats, empties);
    $display("Corner ranges covered the whole space, host and paired addresses %s",
             "and the longest split.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures seen.", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/rtcp_pkg.sv
rtl/core/rtcp_front.sv
rtl/core/rtcp_queue.sv
rtl/core/rtcp_back.sv
rtl/core/range_to_cidr_prefixes_unit.sv
rtl/core/rtcp_checker.sv
dv/range_to_cidr_prefixes_unit_checker.sv
dv/range_to_cidr_prefixes_unit_test.sv
